>>> src/bounding_sphere_from_points_assert.svh
// Assertion macros for the bounding sphere block.
// Used by the checker module; no other dependencies.
`ifndef BOUNDING_SPHERE_FROM_POINTS_ASSERT_SVH
`define BOUNDING_SPHERE_FROM_POINTS_ASSERT_SVH
// Implication checked every clock, quiet in reset.
`define BSP_ASSERT_IMP(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Next-cycle implication, quiet in reset.
`define BSP_ASSERT_NEXT(label, clk, rst, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

>>> src/bsp_pkg.sv
// Package for the bounding sphere block: payload types, constants.
// No dependencies.
package bsp_pkg;
  localparam int MaxPointsDefault = 1024;
  localparam int CoordW = 24;
  localparam int ScaleW = 17;
  localparam int RadiusW = 26;
  localparam int DistW = 50;
  localparam logic [ScaleW-1:0] ScaleReset = 17'd65601;
  localparam logic [RadiusW-1:0] RadiusMax = '1;

  typedef struct packed {
    logic signed [CoordW-1:0] point_x;
    logic signed [CoordW-1:0] point_y;
    logic signed [CoordW-1:0] point_z;
    logic point_valid;
    logic last_point;
  } point_in_t;

  typedef struct packed {
    logic signed [CoordW-1:0] center_x;
    logic signed [CoordW-1:0] center_y;
    logic signed [CoordW-1:0] center_z;
    logic [RadiusW-1:0] radius;
    logic overflowed;
  } sphere_out_t;
endpackage

>>> src/bounding_sphere_from_points.sv
// Bounding sphere top level: point store, box tracking, distance pass sequencer.
// Depends on bsp_pkg, bsp_ram, bsp_sqrt.
// Point items are taken while the block is idle and holds no result. The
// item marked last starts the closing work: a center step, then a distance
// pass through one shared subtract/square unit that reads each stored point
// once (one read, then a square and a compare per axis), then the bit-serial
// square root, then the steps that scale, round and post the result.
// No input is taken during the closing work; the result sits in an output
// register until transferred, and up to MAX_POINTS points are kept per set.
module bounding_sphere_from_points #(
  parameter int MAX_POINTS = bsp_pkg::MaxPointsDefault
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  bsp_pkg::point_in_t in_data,
  output logic out_valid,
  input  logic out_stall,
  output bsp_pkg::sphere_out_t out_data,
  input  logic cfg_valid,
  output logic cfg_ready,
  input  logic [bsp_pkg::ScaleW-1:0] cfg_data
);
  import bsp_pkg::*;
  localparam int AddrW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
  localparam int CntW = $clog2(MAX_POINTS + 1);
  localparam int ProdW = 2*CoordW+2;
  localparam int ScaledW = DistW/2+ScaleW;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_CENTER = 9'b000000010,
    S_READ   = 9'b000000100,
    S_SQ     = 9'b000001000,
    S_CMP    = 9'b000010000,
    S_ROOT   = 9'b000100000,
    S_SCALE  = 9'b001000000,
    S_ROUND  = 9'b010000000,
    S_OUT    = 9'b100000000
  } state_t;

  state_t state;
  logic [ScaleW-1:0] radius_scale;
  logic [CntW-1:0] stored_count;
  logic signed [CoordW-1:0] box_min [3];
  logic signed [CoordW-1:0] box_max [3];
  logic signed [CoordW-1:0] center [3];
  logic overflow_seen;
  logic [DistW-1:0] max_dist_sq;
  logic [DistW-1:0] dist_acc;
  logic [AddrW-1:0] rd_idx;
  logic [1:0] axis;
  logic [3*CoordW-1:0] rd_data;
  logic accept;
  logic store_ok;
  logic we;
  logic signed [CoordW:0] diff;
  logic [CoordW:0] abs_d;
  logic [2*CoordW+1:0] prod;
  logic [2*CoordW+1:0] sq_reg;
  logic sqrt_start;
  logic sqrt_done;
  logic [DistW/2-1:0] root;
  logic [DistW/2+ScaleW-1:0] scaled;
  logic [DistW/2+ScaleW-1:0] rounded;
  logic signed [CoordW:0] sum_a [3];
  logic signed [CoordW-1:0] pt [3];

  assign accept = in_valid && !in_stall;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign cfg_ready = 1'b1;
  assign store_ok = stored_count < CntW'(MAX_POINTS);
  assign we = accept && in_data.point_valid && store_ok;
  assign pt[0] = in_data.point_x;
  assign pt[1] = in_data.point_y;
  assign pt[2] = in_data.point_z;

  bsp_ram #(.Width(3*CoordW), .Depth(MAX_POINTS)) u_store (
    .clk(clk), .we(we), .waddr(AddrW'(stored_count)),
    .wdata({in_data.point_x, in_data.point_y, in_data.point_z}),
    .raddr(rd_idx), .rdata(rd_data)
  );

  bsp_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sqrt_start), .value(max_dist_sq),
    .done(sqrt_done), .root(root)
  );
  assign sqrt_start = (state == S_ROOT) && !sqrt_done && (axis == 2'd0);

  // Shared subtract/square unit, one axis at a time.
  always_comb begin
    case (axis)
      2'd0: diff = (CoordW+1)'(signed'(rd_data[3*CoordW-1:2*CoordW]))
                   - (CoordW+1)'(center[0]);
      2'd1: diff = (CoordW+1)'(signed'(rd_data[2*CoordW-1:CoordW]))
                   - (CoordW+1)'(center[1]);
      default: diff = (CoordW+1)'(signed'(rd_data[CoordW-1:0]))
                      - (CoordW+1)'(center[2]);
    endcase
    abs_d = diff[CoordW] ? (CoordW+1)'(0) - diff : diff;
    prod = ProdW'(abs_d) * ProdW'(abs_d);
    for (int a = 0; a < 3; a++)
      sum_a[a] = (CoordW+1)'(box_min[a]) + (CoordW+1)'(box_max[a]);
    rounded = scaled + ScaledW'(32768);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      radius_scale <= ScaleReset;
      stored_count <= '0;
      overflow_seen <= 1'b0;
      out_valid <= 1'b0;
      axis <= '0;
      for (int a = 0; a < 3; a++) begin
        box_min[a] <= {1'b0, {(CoordW-1){1'b1}}};
        box_max[a] <= {1'b1, {(CoordW-1){1'b0}}};
      end
    end else begin
      if (cfg_valid && cfg_ready) radius_scale <= cfg_data;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          if (accept) begin
            if (in_data.point_valid) begin
              if (store_ok) begin
                stored_count <= stored_count + CntW'(1);
                for (int a = 0; a < 3; a++) begin
                  if (pt[a] < box_min[a]) box_min[a] <= pt[a];
                  if (pt[a] > box_max[a]) box_max[a] <= pt[a];
                end
              end else begin
                overflow_seen <= 1'b1;
              end
            end
            if (in_data.last_point) state <= S_CENTER;
          end
        end
        S_CENTER: begin
          // Floor midpoint; an empty set leaves the center at zero.
          for (int a = 0; a < 3; a++)
            center[a] <= (stored_count == '0) ? '0 : sum_a[a][CoordW:1];
          max_dist_sq <= '0;
          rd_idx <= '0;
          axis <= '0;
          dist_acc <= '0;
          state <= (stored_count == '0) ? S_ROOT : S_READ;
        end
        S_READ: state <= S_SQ;
        S_SQ: begin
          sq_reg <= prod;
          state <= S_CMP;
        end
        S_CMP: begin
          if (axis == 2'd2) begin
            if (dist_acc + DistW'(sq_reg) > max_dist_sq)
              max_dist_sq <= dist_acc + DistW'(sq_reg);
            dist_acc <= '0;
            axis <= '0;
            if (CntW'(rd_idx) + CntW'(1) == stored_count) begin
              state <= S_ROOT;
            end else begin
              rd_idx <= rd_idx + AddrW'(1);
              state <= S_READ;
            end
          end else begin
            dist_acc <= dist_acc + DistW'(sq_reg);
            axis <= axis + 2'd1;
            state <= S_SQ;
          end
        end
        S_ROOT: begin
          // axis nonzero marks the root as started
          if (sqrt_done) begin
            axis <= '0;
            state <= S_SCALE;
          end else begin
            axis <= 2'd1;
          end
        end
        S_SCALE: begin
          scaled <= ScaledW'(root) * ScaledW'(radius_scale);
          state <= S_ROUND;
        end
        S_ROUND: begin
          out_data.center_x <= center[0];
          out_data.center_y <= center[1];
          out_data.center_z <= center[2];
          out_data.overflowed <= overflow_seen;
          if (stored_count == '0)
            out_data.radius <= '0;
          else if (rounded[DistW/2+ScaleW-1:16] > RadiusMax)
            out_data.radius <= RadiusMax;
          else
            out_data.radius <= RadiusW'(rounded[DistW/2+ScaleW-1:16]);
          state <= S_OUT;
        end
        S_OUT: begin
          out_valid <= 1'b1;
          stored_count <= '0;
          overflow_seen <= 1'b0;
          for (int a = 0; a < 3; a++) begin
            box_min[a] <= {1'b0, {(CoordW-1){1'b1}}};
            box_max[a] <= {1'b1, {(CoordW-1){1'b0}}};
          end
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> src/bsp_ram.sv
// Generic single-port-write, registered-read RAM.
// No dependencies.
module bsp_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic clk,
  input  logic we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0] wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0] rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

>>> src/bsp_sqrt.sv
// Iterative integer square root, one result bit per cycle.
// Depends on bsp_pkg.
module bsp_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [bsp_pkg::DistW-1:0] value,
  output logic done,
  output logic [bsp_pkg::DistW/2-1:0] root
);
  import bsp_pkg::*;
  localparam int RootW = DistW / 2;
  localparam int CntW = $clog2(RootW + 1);
  logic [DistW-1:0] rem;
  logic [DistW-1:0] src;
  logic [CntW-1:0] cnt;
  logic busy;
  logic [RootW+1:0] trial;
  logic [RootW+1:0] rem_top;
  logic [RootW+1:0] rem_next;

  // Two bits of the radicand enter the partial remainder per step.
  always_comb begin
    rem_top = {rem[RootW-1:0], src[DistW-1:DistW-2]};
    trial = {root, 2'b01};
    rem_next = rem_top - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        src <= value;
        rem <= '0;
        root <= '0;
        cnt <= CntW'(RootW);
      end else if (busy) begin
        src <= {src[DistW-3:0], 2'b00};
        if (rem_top >= trial) begin
          rem <= DistW'(rem_next);
          root <= {root[RootW-2:0], 1'b1};
        end else begin
          rem <= DistW'(rem_top);
          root <= {root[RootW-2:0], 1'b0};
        end
        cnt <= cnt - CntW'(1);
        if (cnt == CntW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end
endmodule

>>> src/bsp_checker.sv
// Port-level checker for the bounding sphere block, bound to the top level.
// Depends on bsp_pkg and the assertion macro header.
`include "bounding_sphere_from_points_assert.svh"
module bsp_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_stall,
  input bsp_pkg::point_in_t in_data,
  input logic out_valid,
  input logic out_stall,
  input bsp_pkg::sphere_out_t out_data
);
  import bsp_pkg::*;
  `BSP_ASSERT_NEXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "result changed while stalled")
  `BSP_ASSERT_IMP(a_no_in_with_out, clk, rst, out_valid, in_stall, "input taken while result pending")
  `BSP_ASSERT_NEXT(a_last_busy, clk, rst, in_valid && !in_stall && in_data.last_point, in_stall, "block took input right after a set closed")
  `BSP_ASSERT_NEXT(a_out_once, clk, rst, out_valid && !out_stall, !out_valid, "result repeated after transfer")
endmodule

bind bounding_sphere_from_points bsp_checker u_bsp_checker (
  .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
  .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
);
